// ===== design/assert_macros.svh =====
// Assertion helpers; empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Fixed-delay implication.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##(dly) (cons)) else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons)

`endif

`endif

// ===== design/eluact_pkg.sv =====
package eluact_pkg;

    // Q30 helpers for the 2^-f table
    localparam int Q30_SHIFT = 30;
    localparam int ROM_W = Q30_SHIFT + 1;          // entries up to 1.0 in Q1.30
    localparam int LOG2E_W = 31;
    localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam int EXP_SERIES_TERMS = 20;

    // final rounding shift: amounts above EXP_SH_MAX always give zero
    localparam int EXP_SH_W = 6;
    localparam int EXP_SH_MAX = 32;

    // pipeline depth of the exp(t)-1 unit
    localparam int EXP_LAT = 7;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA    = 2'd0,
        CFG_OUT_GAIN = 2'd1,
        CFG_IN_GAIN  = 2'd2
    } t_cfg_idx;

    // exp(-y) for 0 <= y < 1, Q30 in and out; elaboration only
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << Q30_SHIFT;
        sum  = term;
        for (int k = 1; k <= EXP_SERIES_TERMS; k++) begin
            term = ((term * y) >> Q30_SHIFT) / 64'(k);
            if ((k & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

// ===== design/elu_activation_core.sv =====
// Scaled ELU, signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits; Q5.10 by
// default). A sample is taken at every clock edge where start is high and busy is low,
// one per clock with no gaps needed, and its result appears on o_activated/o_saturated
// for exactly one cycle with o_valid high; results leave in the order samples came in.
// There is no back-pressure: whoever sits downstream must take every result as it is
// strobed. busy is high only for the first cycle after reset. The pipeline runs
// input-gain multiply and round/clip, the seven-stage exp(t)-1 unit, alpha multiply
// and round/clip, then output-gain multiply and round/clip. Configuration writes
// (alpha, output gain, input gain) take effect at once and should only be made with
// the pipe empty. o_saturated flags a clip of t, of alpha*(exp(t)-1) on the negative
// branch, or of the final result.
`include "assert_macros.svh"

module elu_activation_core #(
    parameter int DATA_WIDTH      = 16,
    parameter int FRAC_BITS       = 10,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic [eluact_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]              i_cfg_wdata,
    input  logic signed [DATA_WIDTH-1:0]       i_sample,
    output logic                               o_valid,
    output logic signed [DATA_WIDTH-1:0]       o_activated,
    output logic                               o_saturated
);
    import eluact_pkg::*;

    localparam int P_W  = 2 * DATA_WIDTH;             // gain products
    localparam int E_W  = FRAC_BITS + 2;              // exp(t)-1, range [-1, 0]
    localparam int M_W  = DATA_WIDTH + E_W;           // alpha product
    // t has to wait for the exp unit plus the alpha multiply and its round/clip
    localparam int SIDE_LAT = EXP_LAT + 2;
    localparam int CORE_LAT = EXP_LAT + 6;
    // 1.0, or the largest positive value where 1.0 does not fit
    localparam logic [DATA_WIDTH-1:0] UNIT_RESET = (FRAC_BITS < DATA_WIDTH - 1) ?
        DATA_WIDTH'(64'd1 << FRAC_BITS) : {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // configuration
    logic signed [DATA_WIDTH-1:0] r_alpha;
    logic signed [DATA_WIDTH-1:0] r_out_gain;
    logic signed [DATA_WIDTH-1:0] r_in_gain;

    logic r_ready;
    logic n_accept;

    // stage 1: sample * input gain
    logic                  r_s1_vld;
    logic signed [P_W-1:0] r_s1_prod;

    // t after rounding and clipping
    logic                         t_vld;
    logic signed [DATA_WIDTH-1:0] t_val;
    logic                         t_sat;

    // exp(t)-1
    logic                  em_vld;
    logic signed [E_W-1:0] em_val;

    // side line carrying t and its flags alongside the exp unit
    logic                         r_side_vld [SIDE_LAT];
    logic signed [DATA_WIDTH-1:0] r_side_t   [SIDE_LAT];
    logic                         r_side_pos [SIDE_LAT];
    logic                         r_side_sat [SIDE_LAT];

    // alpha * (exp(t)-1)
    logic                  r_m1_vld;
    logic signed [M_W-1:0] r_m1_prod;
    logic                         m_vld;
    logic signed [DATA_WIDTH-1:0] m_val;
    logic                         m_sat;

    // output gain
    logic signed [DATA_WIDTH-1:0] n_y_op;
    logic                         n_y_flag;
    logic                         r_y1_vld;
    logic signed [P_W-1:0]        r_y1_prod;
    logic                         r_y1_flag;
    logic                         r_y2_flag;
    logic                         y_sat;

    // Busy for one cycle out of reset, then open every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy     = ~r_ready;
    assign n_accept = start & r_ready;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= UNIT_RESET;
            r_out_gain <= UNIT_RESET;
            r_in_gain  <= UNIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALPHA:    r_alpha    <= i_cfg_wdata;
                CFG_OUT_GAIN: r_out_gain <= i_cfg_wdata;
                CFG_IN_GAIN:  r_in_gain  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod <= i_sample * r_in_gain;
    end

    eluact_round_clip #(
        .IN_W       (P_W),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_rc_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld),
        .i_prod  (r_s1_prod),
        .o_valid (t_vld),
        .o_value (t_val),
        .o_sat   (t_sat)
    );

    // Negative branch: exp(t)-1. Fed every item; the positive branch ignores it.
    eluact_exp_unit #(
        .DATA_WIDTH      (DATA_WIDTH),
        .FRAC_BITS       (FRAC_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (t_vld),
        .i_t     (t_val),
        .o_valid (em_vld),
        .o_em1   (em_val)
    );

    // Side line: t, branch select and the t clip flag, lined up with m.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIDE_LAT; i++) begin
                r_side_vld[i] <= 1'b0;
            end
        end else begin
            r_side_vld[0] <= t_vld;
            for (int i = 1; i < SIDE_LAT; i++) begin
                r_side_vld[i] <= r_side_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side_t[0]   <= t_val;
        r_side_pos[0] <= t_val > 0;           // t == 0 goes down the exp path
        r_side_sat[0] <= t_sat;
        for (int i = 1; i < SIDE_LAT; i++) begin
            r_side_t[i]   <= r_side_t[i-1];
            r_side_pos[i] <= r_side_pos[i-1];
            r_side_sat[i] <= r_side_sat[i-1];
        end
    end

    // alpha * (exp(t)-1).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= em_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_prod <= r_alpha * em_val;
    end

    eluact_round_clip #(
        .IN_W       (M_W),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_rc_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m1_vld),
        .i_prod  (r_m1_prod),
        .o_valid (m_vld),
        .o_value (m_val),
        .o_sat   (m_sat)
    );

    // Output gain, one multiplier shared by both branches.
    always_comb begin
        n_y_op   = r_side_pos[SIDE_LAT-1] ? r_side_t[SIDE_LAT-1] : m_val;
        // the alpha clip only counts on the negative branch
        n_y_flag = r_side_sat[SIDE_LAT-1] | (~r_side_pos[SIDE_LAT-1] & m_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y1_vld <= 1'b0;
        end else begin
            r_y1_vld <= m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y1_prod <= n_y_op * r_out_gain;
        r_y1_flag <= n_y_flag;
        r_y2_flag <= r_y1_flag;
    end

    eluact_round_clip #(
        .IN_W       (P_W),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_rc_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_y1_vld),
        .i_prod  (r_y1_prod),
        .o_valid (o_valid),
        .o_value (o_activated),
        .o_sat   (y_sat)
    );

    assign o_saturated = y_sat | r_y2_flag;

    `ASSERT_DELAY(a_core_latency, i_clk, i_rst_n, start && !busy, CORE_LAT, o_valid)
    `ASSERT_IMPLIES(a_idle_out_of_reset, i_clk, i_rst_n, busy, !o_valid)
    `ASSERT_IMPLIES(a_side_align, i_clk, i_rst_n, 1'b1, m_vld == r_side_vld[SIDE_LAT-1])

endmodule

// ===== design/eluact_round_clip.sv =====
`include "assert_macros.svh"

module eluact_round_clip #(
    parameter int IN_W       = 32,
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [IN_W-1:0]       i_prod,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic                         o_sat
);
    // extra headroom so the half-LSB add and the shift never overflow
    localparam int EXT_W = IN_W + FRAC_BITS + 2;
    localparam logic signed [EXT_W-1:0] HALF = EXT_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [EXT_W-1:0] MAXV = EXT_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic signed [EXT_W-1:0] MINV = ~MAXV;

    logic signed [EXT_W-1:0] n_sum;
    logic signed [EXT_W-1:0] n_shr;
    logic                    n_hi;
    logic                    n_lo;

    logic                         r_valid;
    logic signed [DATA_WIDTH-1:0] r_value;
    logic                         r_sat;

    // round half up, then clip
    always_comb begin
        n_sum = EXT_W'(i_prod) + HALF;
        n_shr = n_sum >>> FRAC_BITS;
        n_hi  = n_shr > MAXV;
        n_lo  = n_shr < MINV;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_hi) begin
            r_value <= MAXV[DATA_WIDTH-1:0];
        end else if (n_lo) begin
            r_value <= MINV[DATA_WIDTH-1:0];
        end else begin
            r_value <= n_shr[DATA_WIDTH-1:0];
        end
        r_sat <= n_hi | n_lo;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule

// ===== design/eluact_pow2_rom.sv =====
module eluact_pow2_rom #(
    parameter int EXP_TABLE_DEPTH = 256,
    parameter int IDX_W           = $clog2(EXP_TABLE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic [IDX_W-1:0]              i_idx,
    output logic [eluact_pkg::ROM_W-1:0]  o_base,
    output logic [eluact_pkg::ROM_W-1:0]  o_slope
);
    import eluact_pkg::*;

    // 2^(-i/N) in Q1.30 and the step to the next entry
    logic [ROM_W-1:0] rom_val [EXP_TABLE_DEPTH];
    logic [ROM_W-1:0] rom_dif [EXP_TABLE_DEPTH];

    logic [ROM_W-1:0] r_base;
    logic [ROM_W-1:0] r_slope;

    for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [63:0] Y0 = (64'(gi) * LN2_Q30) / EXP_TABLE_DEPTH;
        localparam logic [63:0] Y1 = (64'(gi + 1) * LN2_Q30) / EXP_TABLE_DEPTH;
        localparam logic [63:0] P0 = exp_neg_q30(Y0);
        localparam logic [63:0] P1 = exp_neg_q30(Y1);
        assign rom_val[gi] = P0[ROM_W-1:0];
        assign rom_dif[gi] = ROM_W'(P0 - P1);
    end

    always_ff @(posedge i_clk) begin
        r_base  <= rom_val[i_idx];
        r_slope <= rom_dif[i_idx];
    end

    assign o_base  = r_base;
    assign o_slope = r_slope;

endmodule

// ===== design/eluact_exp_unit.sv =====
`include "assert_macros.svh"

module eluact_exp_unit #(
    parameter int DATA_WIDTH      = 16,
    parameter int FRAC_BITS       = 10,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [DATA_WIDTH-1:0] i_t,
    output logic                         o_valid,
    output logic signed [FRAC_BITS+1:0]  o_em1
);
    import eluact_pkg::*;

    localparam int U_FRAC  = FRAC_BITS + Q30_SHIFT;
    localparam int U_W     = DATA_WIDTH + LOG2E_W + FRAC_BITS;
    localparam int N_W     = U_W - U_FRAC;
    localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
    localparam int POS_W   = Q30_SHIFT + $clog2(EXP_TABLE_DEPTH + 1);
    localparam int SH_BIAS = Q30_SHIFT - FRAC_BITS;
    localparam int PROD_W  = ROM_W + Q30_SHIFT;
    localparam int RND_W   = ROM_W + 3;
    localparam int E_W     = FRAC_BITS + 2;
    localparam logic [E_W-1:0] ONE = E_W'(64'd1 << FRAC_BITS);
    localparam logic signed [E_W-1:0] EM1_MIN = -$signed(ONE);

    logic [EXP_LAT-1:0] r_vld;

    // stage 1: magnitude of the non-positive argument
    logic [DATA_WIDTH-1:0] r1_a;
    // stage 2: u = |t| * log2(e)
    logic [U_W-1:0]        r2_u;
    // stage 3: table index, interpolation weight, shift
    logic [U_W-U_FRAC-1:0] n3_int;
    logic [Q30_SHIFT-1:0]  n3_frac;
    logic [POS_W-1:0]      n3_pos;
    logic [N_W:0]          n3_sh;
    logic [IDX_W-1:0]      r3_idx;
    logic [Q30_SHIFT-1:0]  r3_rem;
    logic [EXP_SH_W-1:0]   r3_s;
    logic                  r3_over;
    // stage 4: table read
    logic [ROM_W-1:0]      rom_base;
    logic [ROM_W-1:0]      rom_slope;
    logic [Q30_SHIFT-1:0]  r4_rem;
    logic [EXP_SH_W-1:0]   r4_s;
    logic                  r4_over;
    // stage 5: slope * weight
    logic [PROD_W-1:0]     r5_prod;
    logic [ROM_W-1:0]      r5_base;
    logic [EXP_SH_W-1:0]   r5_s;
    logic                  r5_over;
    // stage 6: interpolated 2^-f
    logic [PROD_W:0]       n6_corr;
    logic [ROM_W-1:0]      r6_v;
    logic [EXP_SH_W-1:0]   r6_s;
    logic                  r6_over;
    // stage 7: rounding shift by the integer part
    logic [RND_W-1:0]      n7_sum;
    logic [RND_W-1:0]      n7_shr;
    logic [FRAC_BITS:0]    n7_e;
    logic [E_W-1:0]        n7_em1;
    logic signed [E_W-1:0] r7_em1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[EXP_LAT-2:0], i_valid};
        end
    end

    always_comb begin
        n3_int  = r2_u[U_W-1:U_FRAC];
        n3_frac = r2_u[U_FRAC-1:FRAC_BITS];
        n3_pos  = POS_W'(n3_frac) * POS_W'(EXP_TABLE_DEPTH);
        n3_sh   = (N_W+1)'(n3_int) + (N_W+1)'(SH_BIAS);

        n6_corr = (PROD_W+1)'(r5_prod) + (PROD_W+1)'(64'd1 << (Q30_SHIFT - 1));

        n7_sum  = RND_W'(r6_v) + (RND_W'(1) << (r6_s - EXP_SH_W'(1)));
        n7_shr  = n7_sum >> r6_s;
        n7_e    = r6_over ? '0 : n7_shr[FRAC_BITS:0];
        n7_em1  = {1'b0, n7_e} - ONE;
    end

    always_ff @(posedge i_clk) begin
        r1_a <= (i_t > 0) ? '0 : DATA_WIDTH'(-i_t);

        r2_u <= U_W'(r1_a) * U_W'(LOG2E_Q30);

        r3_idx  <= n3_pos[Q30_SHIFT +: IDX_W];
        r3_rem  <= n3_pos[Q30_SHIFT-1:0];
        r3_s    <= n3_sh[EXP_SH_W-1:0];
        r3_over <= n3_sh > (N_W+1)'(EXP_SH_MAX);

        r4_rem  <= r3_rem;
        r4_s    <= r3_s;
        r4_over <= r3_over;

        r5_prod <= PROD_W'(rom_slope) * PROD_W'(r4_rem);
        r5_base <= rom_base;
        r5_s    <= r4_s;
        r5_over <= r4_over;

        r6_v    <= r5_base - n6_corr[Q30_SHIFT +: ROM_W];
        r6_s    <= r5_s;
        r6_over <= r5_over;

        r7_em1  <= $signed(n7_em1);
    end

    eluact_pow2_rom #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
        .IDX_W           (IDX_W)
    ) u_rom (
        .i_clk   (i_clk),
        .i_idx   (r3_idx),
        .o_base  (rom_base),
        .o_slope (rom_slope)
    );

    assign o_valid = r_vld[EXP_LAT-1];
    assign o_em1   = r7_em1;

    `ASSERT_DELAY(a_exp_latency, i_clk, i_rst_n, i_valid, EXP_LAT, o_valid)
    `ASSERT_IMPLIES(a_em1_range, i_clk, i_rst_n, o_valid, (o_em1 <= 0) && (o_em1 >= EM1_MIN))
    `ASSERT_NEXT(a_exp_underflow, i_clk, i_rst_n, r_vld[EXP_LAT-2] && r6_over, o_em1 == EM1_MIN)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

import eluact_pkg::*;

typedef struct packed {
    logic signed [15:0] activated;
    logic               saturated;
} activation_t;

class activation_scoreboard;
    localparam int DW = 16;
    localparam int FB = 10;
    localparam int TAB_DEPTH = 256;
    localparam int QS = 30;
    localparam longint MAXV = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint MINV = -MAXV - 1;
    localparam longint unsigned LOG2E_Q = 64'd1549082005;
    localparam longint unsigned LN2_Q = 64'd744261118;

    longint unsigned pow2_tab[0:TAB_DEPTH];
    longint alpha_q;
    longint out_gain_q;
    longint in_gain_q;
    activation_t expected_acts[$];
    int mismatches;
    int results_seen;
    int neg_branch;
    int clipped;

    function new();
        for (int i = 0; i <= TAB_DEPTH; i++) begin
            pow2_tab[i] = exp_neg_series((longint'(i) * LN2_Q) / TAB_DEPTH);
        end
        alpha_q = 1024;
        out_gain_q = 1024;
        in_gain_q = 1024;
    endfunction

    // exp(-y), 0 <= y < 1, Q30 in and out, alternating series
    function longint unsigned exp_neg_series(longint unsigned y);
        longint unsigned term;
        longint sum;
        term = 64'd1 << QS;
        sum = term;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * y) >> QS) / longint'(k);
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return sum;
    endfunction

    function longint round_mul(longint a, longint b);
        longint w;
        w = a * b + (longint'(1) <<< (FB - 1));
        return w >>> FB;
    endfunction

    function longint clamp(longint v, inout bit hit);
        if (v > MAXV) begin
            hit = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            hit = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    // exp(t) - 1 for t <= 0: 2^-u, integer part of u as a shift, fraction
    // through the table with linear interpolation
    function longint expm1_nonpos(longint t);
        longint unsigned a, u, n, fr, pos, idx, rem, d, v, s, e;
        a = -t;
        u = a * LOG2E_Q;
        n = u >> (FB + QS);
        fr = (u & ((64'd1 << (FB + QS)) - 1)) >> FB;
        pos = fr * TAB_DEPTH;
        idx = pos >> QS;
        rem = pos & ((64'd1 << QS) - 1);
        if (idx >= TAB_DEPTH) begin
            idx = TAB_DEPTH - 1;
        end
        d = pow2_tab[idx] - pow2_tab[idx + 1];
        v = pow2_tab[idx] - ((d * rem + (64'd1 << (QS - 1))) >> QS);
        if (n > 62) begin
            e = 0;
        end else begin
            s = n + (QS - FB);
            e = (s >= 63) ? 64'd0 : ((v + (64'd1 << (s - 1))) >> s);
        end
        return longint'(e) - (longint'(1) <<< FB);
    endfunction

    function activation_t predict_activation(logic signed [DW-1:0] x);
        longint xs, t, m, y;
        bit hit;
        activation_t r;
        hit = 1'b0;
        xs = x;
        t = clamp(round_mul(xs, in_gain_q), hit);
        if (t > 0) begin
            y = clamp(round_mul(t, out_gain_q), hit);
        end else begin
            m = clamp(round_mul(alpha_q, expm1_nonpos(t)), hit);
            y = clamp(round_mul(m, out_gain_q), hit);
            neg_branch++;
        end
        r.activated = y[DW-1:0];
        r.saturated = hit;
        return r;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic signed [DW-1:0] val);
        case (idx)
            CFG_ALPHA:    alpha_q = val;
            CFG_OUT_GAIN: out_gain_q = val;
            CFG_IN_GAIN:  in_gain_q = val;
            default:      ;
        endcase
    endfunction

    function void note_sample(logic signed [DW-1:0] x);
        activation_t r;
        r = predict_activation(x);
        if (r.saturated) begin
            clipped++;
        end
        expected_acts.push_back(r);
    endfunction

    function void check_result(logic signed [DW-1:0] act, logic sat);
        activation_t r;
        results_seen++;
        if (expected_acts.size() == 0) begin
            $error("unexpected result: activated %0d saturated %0d", act, sat);
            mismatches++;
            return;
        end
        r = expected_acts.pop_front();
        if (act !== r.activated) begin
            $error("activated: expected %0d, actual %0d", r.activated, act);
            mismatches++;
        end
        if (sat !== r.saturated) begin
            $error("saturated: expected %0d, actual %0d", r.saturated, sat);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_acts.size();
    endfunction
endclass

module testbench;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS = 10;
    localparam int EXP_TABLE_DEPTH = 256;
    // pipe depth is 13; settle a little beyond it before touching the registers
    localparam int SETTLE_CYCLES = 20;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 154;
    localparam int IDLE_PCT = 12;
    // index past the last register: the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_ALPHA;
    logic [DATA_WIDTH-1:0] i_cfg_wdata = '0;
    logic signed [DATA_WIDTH-1:0] i_sample = '0;
    logic o_valid;
    logic signed [DATA_WIDTH-1:0] o_activated;
    logic o_saturated;

    activation_scoreboard sb = new();
    int samples_sent = 0;
    int phases_run = 0;

    elu_activation_core #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS(FRAC_BITS),
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_sample(i_sample),
        .o_valid(o_valid),
        .o_activated(o_activated),
        .o_saturated(o_saturated)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is a transfer. Outputs are
    // read just after the edge, i.e. the values held during the closing cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_activated, o_saturated);
        end
    end

    // Hard stop, far beyond the length of a normal run.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // One register write per edge; the caller lowers the enable afterwards so
    // back-to-back writes never toggle it within one step.
    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_WIDTH-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // Transfer one sample; each cycle beforehand idles with idle_pct chance.
    // start stays high between back-to-back transfers.
    task automatic send_sample(logic signed [DATA_WIDTH-1:0] x, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_sample <= x;
        do begin
            @(posedge i_clk);
        end while (busy);
        sb.note_sample(x);
        samples_sent++;
    endtask

    // Sender goes quiet until the pipe is empty, then lets it settle.
    task automatic drain_pipe();
        start <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'sd1024;
            4: return -16'sd1024;
            5: return 16'($signed($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly full-range samples, plus a share near zero where the table
    // interpolation and rounding matter, and a share on the negative side.
    function automatic logic signed [DATA_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3, 4: return 16'($urandom);
            5, 6, 7: return 16'($signed($urandom_range(0, 6144)) - 3072);
            default: return 16'(-$signed($urandom_range(0, 12288)));
        endcase
    endfunction

    initial begin
        logic signed [DATA_WIDTH-1:0] directed[$];
        int idle;
        directed = '{16'sd0, 16'sd1, -16'sd1, 16'sh7fff, 16'sh8000, 16'sd1024,
                     -16'sd1024, 16'sd512, -16'sd512, 16'sd2048, -16'sd2048,
                     16'sd5000, -16'sd5000, 16'sh5555, 16'shaaaa, -16'sd10000,
                     -16'sd20000, 16'sd100, -16'sd100, -16'sd1536, 16'sd12345};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset gains, zero argument, range ends, deep negative
        // tail where exp underflows, alternating bit patterns.
        foreach (directed[k]) begin
            send_sample(directed[k], IDLE_PCT);
        end
        drain_pipe();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    put_reg(CFG_ALPHA, 16'sd1024);
                    put_reg(CFG_OUT_GAIN, 16'sd1024);
                    put_reg(CFG_IN_GAIN, 16'sd1024);
                    put_reg(CFG_SPARE, 16'h8001);
                end
                1: begin
                    put_reg(CFG_ALPHA, 16'h7fff);
                    put_reg(CFG_OUT_GAIN, 16'h7fff);
                    put_reg(CFG_IN_GAIN, 16'h7fff);
                end
                2: begin
                    put_reg(CFG_ALPHA, 16'h8000);
                    put_reg(CFG_OUT_GAIN, 16'h8000);
                    put_reg(CFG_IN_GAIN, 16'h8000);
                end
                3: begin
                    put_reg(CFG_ALPHA, 16'h0000);
                    put_reg(CFG_OUT_GAIN, 16'h7fff);
                    put_reg(CFG_IN_GAIN, 16'sd256);
                    put_reg(CFG_SPARE, 16'h7ffe);
                end
                default: begin
                    put_reg(CFG_ALPHA, pick_gain());
                    put_reg(CFG_OUT_GAIN, pick_gain());
                    put_reg(CFG_IN_GAIN, pick_gain());
                end
            endcase
            i_cfg_we <= 1'b0;
            @(posedge i_clk);

            // phase 4 runs flat out, one transfer every clock
            idle = (ph == 4) ? 0 : IDLE_PCT;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_sample(pick_sample(), idle);
            end
            drain_pipe();
            phases_run++;
        end

        $display("Sent %0d samples across %0d gain settings plus the reset defaults;",
                 samples_sent, phases_run);
        $display("%0d results checked, %0d on the exponential branch, %0d clipped.",
                 sb.results_seen, sb.neg_branch, sb.clipped);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
